// ===== design/brlt_pkg.sv =====
// brlt_pkg: types and codes shared by the byte-range lock table modules
// depends on nothing
`default_nettype none
package brlt_pkg;

    typedef enum logic [2:0] {
        CMD_LOCK       = 3'd0,
        CMD_UNLOCK_ONE = 3'd1,
        CMD_UNLOCK_ALL = 3'd2,
        CMD_CHECK_RD   = 3'd3,
        CMD_CHECK_WR   = 3'd4
    } cmd_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_RANGE   = 3'd1;
    localparam logic [2:0] ST_NOT_GRANTED = 3'd2;
    localparam logic [2:0] ST_NOT_LOCKED  = 3'd3;
    localparam logic [2:0] ST_CONFLICT    = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;

    // classified request word passed from front to back
    typedef struct packed {
        logic [2:0]  cmd;
        logic        active;
        logic        bad_range;
        logic [7:0]  handle;
        logic [31:0] key;
        logic [63:0] offset;
        logic [63:0] length;
        logic [63:0] last;
        logic        excl;
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SCAN2,
        S_WRITE,
        S_DONE
    } state_t;

    // range overlap with zero-length boundary rule
    function automatic logic ranges_meet(
        input logic [63:0] o1, input logic [63:0] l1, input logic [63:0] e1,
        input logic [63:0] o2, input logic [63:0] l2, input logic [63:0] e2);
        logic r;
        begin
            if (l1 == 64'd0 && l2 == 64'd0) begin
                r = 1'b0;
            end else if (l1 == 64'd0) begin
                r = (o1 > o2) && (o1 <= e2);
            end else if (l2 == 64'd0) begin
                r = (o2 > o1) && (o2 <= e1);
            end else begin
                r = (o1 <= e2) && (o2 <= e1);
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/brlt_ram.sv =====
// brlt_ram: generic single-port ram with registered read
// depends on nothing
`default_nettype none
module brlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  addr,
    input  wire [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== design/brlt_front.sv =====
// brlt_front: accepts command words, classifies them, two-entry queue to back end
// depends on brlt_pkg
`default_nettype none
module brlt_front #(
    parameter int HANDLE_COUNT = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [2:0]          s_command,
    input  wire  [3:0]          s_handle,
    input  wire  [31:0]         s_lock_key,
    input  wire  [63:0]         s_range_offset,
    input  wire  [63:0]         s_range_length,
    input  wire                 s_want_exclusive,
    output logic                q_valid,
    input  wire                 q_ready,
    output brlt_pkg::req_t      q_req
);
    brlt_pkg::req_t   cls;
    brlt_pkg::req_t   buf_reg [2];
    logic             rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    // classify incoming word
    always_comb begin
        cls.cmd       = s_command;
        cls.active    = ({28'd0, s_handle} < 32'(HANDLE_COUNT)) &&
                        (s_command <= 3'(brlt_pkg::CMD_CHECK_WR));
        cls.handle    = {4'd0, s_handle};
        cls.key       = s_lock_key;
        cls.offset    = s_range_offset;
        cls.length    = s_range_length;
        cls.last      = s_range_offset + s_range_length - 64'd1;
        cls.bad_range = (s_range_length != 64'd0) && (cls.last < s_range_offset);
        cls.excl      = s_want_exclusive;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_req   = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/brlt_back.sv =====
// brlt_back: scans the slot table one entry per cycle and applies the command
// depends on brlt_pkg, brlt_ram
`default_nettype none
module brlt_back #(
    parameter int TABLE_SLOTS = 64
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    output logic                q_ready,
    input  brlt_pkg::req_t      q_req,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_status,
    output logic                m_any_locks_held
);
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int EW = 4 + 32 + 64 + 64 + 1;

    brlt_pkg::state_t  state_reg, state_next;
    brlt_pkg::req_t    req_reg;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     free_reg, free_next;
    logic              free_found_reg, free_found_next;
    logic              hit_reg, hit_next;
    logic              pass_reg, pass_next;
    logic              found_reg, found_next;
    logic [2:0]        st_reg, st_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_st_reg;
    logic              out_any_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [EW-1:0]     ram_wdata, ram_rdata;
    logic [AW-1:0]     rd_idx_reg;
    logic              last_idx;

    logic [3:0]        e_handle;
    logic [31:0]       e_key;
    logic [63:0]       e_off, e_len, e_last;
    logic              e_excl, e_valid, meet, own;

    brlt_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // unpack the entry read last cycle
    always_comb begin
        {e_handle, e_key, e_off, e_len, e_excl} = ram_rdata;
        e_last  = e_off + e_len - 64'd1;
        e_valid = valid_reg[rd_idx_reg];
        meet    = brlt_pkg::ranges_meet(req_reg.offset, req_reg.length, req_reg.last,
                                        e_off, e_len, e_last);
        own     = ({4'd0, e_handle} == req_reg.handle) && (e_key == req_reg.key);
        last_idx = (rd_idx_reg == AW'(TABLE_SLOTS - 1));
    end

    assign q_ready = (state_reg == brlt_pkg::S_IDLE) && !out_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brlt_pkg::S_IDLE:  if (q_valid && q_ready) begin
                state_next = brlt_pkg::S_READ;
            end
            brlt_pkg::S_READ:  state_next = brlt_pkg::S_SCAN;
            brlt_pkg::S_SCAN:  if (hit_next || last_idx) begin
                state_next = (req_reg.cmd == 3'(brlt_pkg::CMD_UNLOCK_ONE) && !pass_reg
                              && !found_next) ? brlt_pkg::S_SCAN2 : brlt_pkg::S_WRITE;
            end
            brlt_pkg::S_SCAN2: state_next = brlt_pkg::S_READ;
            brlt_pkg::S_WRITE: state_next = brlt_pkg::S_DONE;
            brlt_pkg::S_DONE:  state_next = brlt_pkg::S_IDLE;
            default:           state_next = brlt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        idx_next        = idx_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        hit_next        = hit_reg;
        pass_next       = pass_reg;
        found_next      = found_reg;
        st_next         = st_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;
        ram_wdata       = {req_reg.handle[3:0], req_reg.key, req_reg.offset,
                           req_reg.length, req_reg.excl};
        case (state_reg)
            brlt_pkg::S_IDLE: begin
                idx_next = '0; free_found_next = 1'b0; hit_next = 1'b0;
                pass_next = 1'b0; found_next = 1'b0; st_next = brlt_pkg::ST_OK;
            end
            brlt_pkg::S_READ: begin
                ram_addr = idx_reg;
                idx_next = idx_reg + AW'(1);
                if (!req_reg.active || (req_reg.cmd == 3'(brlt_pkg::CMD_LOCK) &&
                    req_reg.bad_range) || ((req_reg.cmd == 3'(brlt_pkg::CMD_CHECK_RD) ||
                    req_reg.cmd == 3'(brlt_pkg::CMD_CHECK_WR)) &&
                    req_reg.length == 64'd0)) begin
                    hit_next = 1'b1;
                    st_next  = req_reg.active && req_reg.cmd == 3'(brlt_pkg::CMD_LOCK)
                               ? brlt_pkg::ST_BAD_RANGE : brlt_pkg::ST_OK;
                end
            end
            brlt_pkg::S_SCAN: begin
                ram_addr = idx_reg;
                idx_next = idx_reg + AW'(1);
                if (!hit_reg) begin
                    case (req_reg.cmd)
                        3'(brlt_pkg::CMD_LOCK): begin
                            if (!e_valid) begin
                                if (!free_found_reg) begin
                                    free_next = rd_idx_reg; free_found_next = 1'b1;
                                end
                            end else if (meet && (req_reg.excl || (e_excl && !own))) begin
                                hit_next = 1'b1; st_next = brlt_pkg::ST_NOT_GRANTED;
                            end
                        end
                        3'(brlt_pkg::CMD_UNLOCK_ONE): begin
                            if (e_valid && own && e_off == req_reg.offset &&
                                e_len == req_reg.length && e_excl == !pass_reg) begin
                                hit_next = 1'b1; found_next = 1'b1;
                                valid_next[rd_idx_reg] = 1'b0;
                            end
                        end
                        3'(brlt_pkg::CMD_UNLOCK_ALL): begin
                            if (e_valid && {4'd0, e_handle} == req_reg.handle &&
                                (req_reg.key == 32'd0 || e_key == req_reg.key)) begin
                                found_next = 1'b1;
                                valid_next[rd_idx_reg] = 1'b0;
                            end
                        end
                        default: begin
                            if (e_valid && meet && ((e_excl && !own) ||
                                (!e_excl && req_reg.cmd == 3'(brlt_pkg::CMD_CHECK_WR)))) begin
                                hit_next = 1'b1; st_next = brlt_pkg::ST_CONFLICT;
                            end
                        end
                    endcase
                end
                // first pass of unlock-one missed: rescan for shared entries
                if ((hit_next || last_idx) && req_reg.cmd == 3'(brlt_pkg::CMD_UNLOCK_ONE) &&
                    !pass_reg && !found_next) begin
                    pass_next = 1'b1; idx_next = '0;
                end
            end
            brlt_pkg::S_WRITE: begin
                ram_addr = free_reg;
                if (!hit_reg || found_reg) begin
                    case (req_reg.cmd)
                        3'(brlt_pkg::CMD_LOCK): begin
                            if (free_found_reg) begin
                                ram_we = 1'b1; valid_next[free_reg] = 1'b1;
                            end else begin
                                st_next = brlt_pkg::ST_FULL;
                            end
                        end
                        3'(brlt_pkg::CMD_UNLOCK_ONE): begin
                            st_next = found_reg ? brlt_pkg::ST_OK : brlt_pkg::ST_NOT_LOCKED;
                        end
                        3'(brlt_pkg::CMD_UNLOCK_ALL): begin
                            st_next = (found_reg || req_reg.key == 32'd0) ?
                                      brlt_pkg::ST_OK : brlt_pkg::ST_NOT_LOCKED;
                        end
                        default: st_next = st_reg;
                    endcase
                end
            end
            brlt_pkg::S_DONE:  out_valid_next = 1'b1;
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= brlt_pkg::S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            req_reg <= q_req;
        end
        idx_reg        <= idx_next;
        rd_idx_reg     <= ram_addr;
        free_reg       <= free_next;
        free_found_reg <= free_found_next;
        hit_reg        <= hit_next;
        pass_reg       <= pass_next;
        found_reg      <= found_next;
        st_reg         <= st_next;
        if (state_reg == brlt_pkg::S_DONE) begin
            out_st_reg  <= st_reg;
            out_any_reg <= |valid_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_st_reg;
    assign m_any_locks_held = out_any_reg;
endmodule
`default_nettype wire

// ===== design/byte_range_lock_table_core.sv =====
// Byte-range lock table: each command scans the slots, one slot per cycle
// through the slot ram read port. Unlock-one may scan the table twice, first for
// exclusive and then for shared entries; a scan stops early on a hit.
// One word is worked at a time: a new word leaves the queue only after the last result is taken.
// Synchronous active-low reset clears slot valid bits; slot contents are not reset.
`default_nettype none
module byte_range_lock_table_core #(
    parameter int TABLE_SLOTS  = 64,
    parameter int HANDLE_COUNT = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_command,
    input  wire  [3:0]  s_handle,
    input  wire  [31:0] s_lock_key,
    input  wire  [63:0] s_range_offset,
    input  wire  [63:0] s_range_length,
    input  wire         s_want_exclusive,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_status,
    output logic        m_any_locks_held
);
    logic             q_valid, q_ready;
    brlt_pkg::req_t   q_req;

    // front end: classify and queue
    brlt_front #(.HANDLE_COUNT(HANDLE_COUNT)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_handle, .s_lock_key,
        .s_range_offset, .s_range_length, .s_want_exclusive,
        .q_valid, .q_ready, .q_req
    );

    // back end: table scan
    brlt_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .m_valid, .m_ready, .m_status, .m_any_locks_held
    );
endmodule
`default_nettype wire

// ===== tb/sv/byte_range_lock_table_core_tb.sv =====
// byte_range_lock_table_core_tb: directed table then random words against a lock-table predictor
// depends on brlt_pkg and byte_range_lock_table_core
`default_nettype none
module byte_range_lock_table_core_tb;

    localparam int SLOTS = 64;
    localparam int N_RANDOM = 680;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [2:0] CMD_RESERVED = 3'd5;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]  cmd;
        logic [3:0]  handle;
        logic [31:0] key;
        logic [63:0] offset;
        logic [63:0] length;
        logic        excl;
    } req_word_t;

    typedef struct {
        logic [2:0] status;
        logic       held;
    } lock_result_t;

    typedef struct {
        req_word_t    w;
        bit           typed;
        lock_result_t r;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = '0;
    logic [3:0]  s_handle = '0;
    logic [31:0] s_lock_key = '0;
    logic [63:0] s_range_offset = '0;
    logic [63:0] s_range_length = '0;
    logic        s_want_exclusive = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_any_locks_held;

    // predictor copy of the lock table
    bit          tbl_valid [SLOTS];
    logic [3:0]  tbl_handle [SLOTS];
    logic [31:0] tbl_key [SLOTS];
    logic [63:0] tbl_offset [SLOTS];
    logic [63:0] tbl_length [SLOTS];
    bit          tbl_excl [SLOTS];

    lock_result_t expected_q[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  long_hold = 1'b0;

    byte_range_lock_table_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_handle(s_handle), .s_lock_key(s_lock_key), .s_range_offset(s_range_offset),
        .s_range_length(s_range_length), .s_want_exclusive(s_want_exclusive),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_any_locks_held(m_any_locks_held)
    );

    always #6 aclk = ~aclk;

    // overlap with the zero-length boundary rule
    function automatic bit spans_meet(logic [63:0] o1, logic [63:0] l1,
                                      logic [63:0] o2, logic [63:0] l2);
        logic [63:0] e1, e2;
        e1 = o1 + l1 - 64'd1;
        e2 = o2 + l2 - 64'd1;
        if (l1 == 0 && l2 == 0) return 1'b0;
        if (l1 == 0) return (o1 > o2) && (o1 <= e2);
        if (l2 == 0) return (o2 > o1) && (o2 <= e1);
        return (o1 <= e2) && (o2 <= e1);
    endfunction

    // apply one word to the table copy and return its result
    function automatic lock_result_t apply_lock_word(req_word_t w);
        lock_result_t r;
        int free_slot;
        bit removed, done;
        r.status = brlt_pkg::ST_OK;
        free_slot = SLOTS;
        removed = 0;
        done = 0;
        case (w.cmd)
            brlt_pkg::CMD_LOCK: begin
                if (w.length != 0 && w.offset + w.length - 64'd1 < w.offset) begin
                    r.status = brlt_pkg::ST_BAD_RANGE;
                end else begin
                    for (int i = 0; i < SLOTS && !done; i++) begin
                        if (!tbl_valid[i]) begin
                            if (free_slot == SLOTS) free_slot = i;
                        end else if (spans_meet(w.offset, w.length,
                                                tbl_offset[i], tbl_length[i])) begin
                            if (tbl_excl[i] ? (w.excl || tbl_handle[i] != w.handle ||
                                               tbl_key[i] != w.key) : w.excl) begin
                                r.status = brlt_pkg::ST_NOT_GRANTED;
                                done = 1;
                            end
                        end
                    end
                    if (!done && free_slot == SLOTS) begin
                        r.status = brlt_pkg::ST_FULL;
                    end else if (!done) begin
                        tbl_valid[free_slot] = 1;
                        tbl_handle[free_slot] = w.handle;
                        tbl_key[free_slot] = w.key;
                        tbl_offset[free_slot] = w.offset;
                        tbl_length[free_slot] = w.length;
                        tbl_excl[free_slot] = w.excl;
                    end
                end
            end
            brlt_pkg::CMD_UNLOCK_ONE: begin
                r.status = brlt_pkg::ST_NOT_LOCKED;
                for (int p = 0; p < 2 && !done; p++) begin
                    for (int i = 0; i < SLOTS && !done; i++) begin
                        if (tbl_valid[i] && tbl_handle[i] == w.handle && tbl_key[i] == w.key &&
                            tbl_offset[i] == w.offset && tbl_length[i] == w.length &&
                            tbl_excl[i] == (p == 0)) begin
                            tbl_valid[i] = 0;
                            r.status = brlt_pkg::ST_OK;
                            done = 1;
                        end
                    end
                end
            end
            brlt_pkg::CMD_UNLOCK_ALL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_handle[i] == w.handle &&
                        (w.key == 0 || tbl_key[i] == w.key)) begin
                        tbl_valid[i] = 0;
                        removed = 1;
                    end
                end
                r.status = (removed || w.key == 0) ? brlt_pkg::ST_OK : brlt_pkg::ST_NOT_LOCKED;
            end
            brlt_pkg::CMD_CHECK_RD, brlt_pkg::CMD_CHECK_WR: begin
                for (int i = 0; i < SLOTS && !done && w.length != 0; i++) begin
                    if (tbl_valid[i] && spans_meet(w.offset, w.length,
                                                   tbl_offset[i], tbl_length[i])) begin
                        if (tbl_excl[i] ? (tbl_handle[i] != w.handle || tbl_key[i] != w.key)
                                        : (w.cmd == brlt_pkg::CMD_CHECK_WR)) begin
                            r.status = brlt_pkg::ST_CONFLICT;
                            done = 1;
                        end
                    end
                end
            end
            default: r.status = brlt_pkg::ST_OK;
        endcase
        r.held = 0;
        for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) r.held = 1;
        return r;
    endfunction

    function automatic req_word_t mk(logic [2:0] c, logic [3:0] h, logic [31:0] k,
                                     logic [63:0] o, logic [63:0] l, logic x);
        req_word_t w;
        w.cmd = c; w.handle = h; w.key = k; w.offset = o; w.length = l; w.excl = x;
        return w;
    endfunction

    function automatic logic [63:0] rand_offset();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8) return 64'($urandom_range(0, 255));
        if (sel == 8) return {$urandom, $urandom};
        return MAX64 - 64'($urandom_range(0, 8));
    endfunction

    function automatic logic [63:0] rand_length();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 3) return 64'd0;
        if (sel < 17) return 64'($urandom_range(1, 40));
        if (sel < 19) return {$urandom, $urandom};
        return MAX64 - 64'($urandom_range(0, 2));
    endfunction

    // mostly well-formed traffic on a small window, some noise
    function automatic req_word_t rand_word();
        req_word_t w;
        int sel, pick;
        int live[$];
        sel = $urandom_range(0, 99);
        w = mk(brlt_pkg::CMD_LOCK, 4'($urandom_range(0, 15)),
               ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3)),
               rand_offset(), rand_length(), $urandom_range(0, 9) < 3);
        if (sel < 45) begin
            w.cmd = brlt_pkg::CMD_LOCK;
        end else if (sel < 60) begin
            w.cmd = brlt_pkg::CMD_UNLOCK_ONE;
            for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) live.push_back(i);
            if (live.size() > 0 && $urandom_range(0, 9) < 7) begin
                pick = live[$urandom_range(0, live.size() - 1)];
                w.handle = tbl_handle[pick];
                w.key = tbl_key[pick];
                w.offset = tbl_offset[pick];
                w.length = tbl_length[pick];
            end
        end else if (sel < 67) begin
            w.cmd = brlt_pkg::CMD_UNLOCK_ALL;
        end else if (sel < 80) begin
            w.cmd = brlt_pkg::CMD_CHECK_RD;
        end else if (sel < 97) begin
            w.cmd = brlt_pkg::CMD_CHECK_WR;
        end else begin
            w.cmd = 3'($urandom_range(CMD_RESERVED, 7));
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // send one word; inputs are assigned at a falling edge and held until s_ready is seen
    task automatic send_word(req_word_t w, bit typed, lock_result_t tr);
        lock_result_t pr;
        @(negedge aclk);
        s_command = w.cmd;
        s_handle = w.handle;
        s_lock_key = w.key;
        s_range_offset = w.offset;
        s_range_length = w.length;
        s_want_exclusive = w.excl;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pr = apply_lock_word(w);
        expected_q.push_back(typed ? tr : pr);
    endtask

    task automatic idle_gap(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
    endtask

    // result side: pattern stalls, free-running stretches, one long hold
    initial begin : result_side
        int period, duty, cnt, left;
        period = 1; duty = 1; cnt = 0; left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready = 1'b0;
                repeat (600) @(negedge aclk);
                long_hold = 1'b0;
            end
            if (left == 0) begin
                left = $urandom_range(20, 200);
                period = $urandom_range(1, 6);
                duty = ($urandom_range(0, 3) == 0) ? period : $urandom_range(1, period);
            end
            left--;
            m_ready = (cnt % period) < duty;
            cnt++;
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin
        lock_result_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word status", m_status, -1);
                end else begin
                    e = expected_q.pop_front();
                    if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                    if (m_any_locks_held !== e.held)
                        report_mismatch("any_locks_held", m_any_locks_held, e.held);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("byte_range_lock_table_core_tb failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        stim_row_t rows[$];
        stim_row_t row;
        int burst;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table; typed results only where obvious
        rows.push_back('{mk(brlt_pkg::CMD_CHECK_RD, 0, 0, 0, 0, 0), 1,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_UNLOCK_ONE, 3, 7, 10, 5, 0), 1,
                         '{brlt_pkg::ST_NOT_LOCKED, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_UNLOCK_ALL, 3, 5, 0, 0, 0), 1,
                         '{brlt_pkg::ST_NOT_LOCKED, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_UNLOCK_ALL, 3, 0, 0, 0, 0), 1,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 0, 1, MAX64, 2, 1), 1,
                         '{brlt_pkg::ST_BAD_RANGE, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 0, 1, 0, MAX64, 1), 1,
                         '{brlt_pkg::ST_OK, 1}});
        rows.push_back('{mk(brlt_pkg::CMD_CHECK_WR, 1, 1, 5, 1, 0), 1,
                         '{brlt_pkg::ST_CONFLICT, 1}});
        rows.push_back('{mk(brlt_pkg::CMD_CHECK_RD, 0, 1, 5, 1, 0), 0, '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_CHECK_RD, 0, 2, MAX64, 4, 0), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 1, 9, 0, 0, 0), 0, '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_UNLOCK_ONE, 0, 1, 0, MAX64, 0), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 2, 4, 100, 100, 0), 0, '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 3, 4, 120, 10, 1), 0, '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 3, 4, 150, 0, 1), 0, '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 2, 4, 100, 100, 1), 0, '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 2, 4, 100, 100, 0), 0, '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_UNLOCK_ONE, 2, 4, 100, 100, 0), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_CHECK_WR, 2, 4, 50, 60, 0), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_LOCK, 5, 32'hFFFF_FFFF, MAX64, 1, 1), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_CHECK_RD, 5, 32'hFFFF_FFFF, MAX64, 1, 0), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_CHECK_RD, 15, 3, MAX64, 1, 1), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(3'd7, 15, 32'hFFFF_FFFF, MAX64, MAX64, 1), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_UNLOCK_ALL, 2, 0, 0, 0, 0), 0,
                         '{brlt_pkg::ST_OK, 0}});
        rows.push_back('{mk(brlt_pkg::CMD_UNLOCK_ALL, 5, 32'hFFFF_FFFF, 0, 0, 0), 0,
                         '{brlt_pkg::ST_OK, 0}});
        foreach (rows[i]) begin
            row = rows[i];
            send_word(row.w, row.typed, row.r);
        end

        // random part in bursts with gaps
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 100) long_hold = 1'b1;
            if (n == 350) begin
                idle_gap(1);
                while (expected_q.size() != 0) @(negedge aclk);
            end
            if (burst == 0) begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
                idle_gap($urandom_range(0, 12));
            end
            burst--;
            send_word(rand_word(), 1'b0, '{brlt_pkg::ST_OK, 0});
        end
        idle_gap(1);

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("byte_range_lock_table_core_tb passed");
        end else begin
            $display("byte_range_lock_table_core_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/brlt_pkg.sv
design/brlt_ram.sv
design/brlt_front.sv
design/brlt_back.sv
design/byte_range_lock_table_core.sv
tb/sv/byte_range_lock_table_core_tb.sv
